// ===== hdl/cbt_pkg.sv =====
// Shared types, constants and codes for the cubic B-spline tessellator.
package cbt_pkg;

	localparam int MAX_SAMPLES = 64;
	localparam int CNT_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

	localparam int T_W    = 17;
	localparam int STEP_W = 17;
	localparam logic [T_W-1:0]    TENSION_LIMIT = 17'd65601;
	localparam logic [STEP_W-1:0] STEP_RESET    = 17'd1638;

	// Weight rounding: divide by 6 * 2^18 = (2^19) * 3.
	localparam logic signed [55:0] WEIGHT_HALF = 56'sd786432;
	localparam logic [31:0]        RECIP3      = 32'hAAAAAAAB;
	localparam logic signed [55:0] ONE_CUBED   = 56'sh1_0000_0000_0000;
	localparam logic signed [65:0] ROUND_HALF  = 66'sd536870912;

	localparam logic [1:0] SEEN_FULL = 2'd3;

	// Configuration port
	localparam int PADDR_W   = 3;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_TENSION_STEP = 1'b0;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic               new_curve;
	} point_t;

	typedef struct packed {
		logic signed [31:0] sample_x;
		logic signed [31:0] sample_y;
		logic signed [31:0] sample_z;
		logic               last_sample;
	} sample_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic start;
		logic issue;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic en;
		logic step_over;
	} dp_sts_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

endpackage

// ===== hdl/cbt_ctrl.sv =====
// Controller: point acceptance, curve history count and per-window sample issue.
module cbt_ctrl import cbt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    point_valid,
	input  logic    new_curve,
	output logic    point_stall,
	input  dp_sts_t sts,
	output cmd_t    cmd
);

	state_t           state_q, state_d;
	logic [1:0]       seen_q, seen_d, seen_eff;
	logic [CNT_W-1:0] n_q, n_d;
	logic             open;
	logic             accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q  <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			seen_q  <= seen_d;
			n_q     <= n_d;
		end
	end

	always_comb begin
		open        = (state_q == ST_IDLE) && !sts.busy;
		accept      = point_valid && open;
		point_stall = !open;
		seen_eff    = new_curve ? 2'd0 : seen_q;

		cmd.load  = accept;
		cmd.clear = accept && new_curve;
		cmd.start = accept && (seen_eff == SEEN_FULL);
		cmd.issue = (state_q == ST_RUN) && sts.en;
		cmd.last  = (n_q == CNT_W'(MAX_SAMPLES - 1)) || sts.step_over;

		state_d = state_q;
		seen_d  = seen_q;
		n_d     = n_q;

		if (accept)
			seen_d = (seen_eff == SEEN_FULL) ? SEEN_FULL : seen_eff + 2'd1;

		case (state_q)
			ST_IDLE: begin
				if (cmd.start) begin
					state_d = ST_RUN;
					n_d     = '0;
				end
			end
			ST_RUN: begin
				if (cmd.issue) begin
					n_d = n_q + CNT_W'(1);
					if (cmd.last)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== hdl/cbt_dp.sv =====
// Datapath: point window, tension counter and the basis-weight / dot-product pipeline.
module cbt_dp import cbt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  point_t            point,
	input  logic [STEP_W-1:0] step,
	input  cmd_t              cmd,
	input  logic              stall,
	output dp_sts_t           sts,
	output logic              out_valid,
	output sample_t           out_sample
);

	logic signed [31:0] win_q [3][4];
	logic signed [31:0] pin [3];
	logic [T_W-1:0]     t_q;
	logic [T_W:0]       t_sum;
	logic               en;

	logic signed [17:0] u_c;
	logic [33:0]        t2_c;
	logic signed [35:0] u2_c;

	logic [8:1]         v_q;
	logic [8:1]         last_q;

	logic [T_W-1:0]     t_s1, t_s2;
	logic signed [17:0] u_s1;
	logic [33:0]        t2_s1, t2_s2;
	logic signed [35:0] u2_s1;
	logic [51:0]        t3_s2;
	logic signed [53:0] u3_s2;

	logic signed [55:0] b_c  [4];
	logic signed [55:0] b_s3 [4];
	logic signed [55:0] mag_c [4];
	logic signed [55:0] magh_c [4];
	logic [31:0]        h_s4 [4];
	logic [3:0]         neg_s4, neg_s5;
	logic [63:0]        rp_c [4];
	logic [30:0]        q_s5 [4];
	logic signed [31:0] w_s6 [4];
	logic signed [63:0] prod_s7 [3][4];
	logic signed [65:0] sum_c  [3];
	logic signed [65:0] sum_s8 [3];
	logic signed [31:0] res_c  [3];
	logic signed [55:0] t3e, t2e, t1e;
	logic               out_valid_q;
	sample_t            out_q;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sh07FFFFFFF)
			r = 32'sh7FFFFFFF;
		else if (v < 36'shF80000000)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	assign en    = !out_valid_q || !stall;
	assign t_sum = {1'b0, t_q} + {1'b0, step};

	assign sts.en        = en;
	assign sts.busy      = |v_q[6:1];
	assign sts.step_over = (t_sum > {1'b0, TENSION_LIMIT});

	assign pin[0] = point.point_x;
	assign pin[1] = point.point_y;
	assign pin[2] = point.point_z;

	// point window: taps 1..3 double as the curve history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++)
				for (int j = 0; j < 4; j++)
					win_q[a][j] <= '0;
		end else if (cmd.load) begin
			for (int a = 0; a < 3; a++) begin
				for (int j = 0; j < 3; j++)
					win_q[a][j] <= cmd.clear ? 32'sd0 : win_q[a][j+1];
				win_q[a][3] <= pin[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			t_q <= '0;
		else if (cmd.start)
			t_q <= '0;
		else if (cmd.issue)
			t_q <= t_sum[T_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_q         <= {v_q[7:1], cmd.issue};
			out_valid_q <= v_q[8];
		end
	end

	// s1: squares
	assign u_c  = 18'sd65536 - $signed({1'b0, t_q});
	assign t2_c = {17'b0, t_q} * {17'b0, t_q};
	assign u2_c = $signed({{18{u_c[17]}}, u_c}) * $signed({{18{u_c[17]}}, u_c});

	// s3: scaled basis polynomials, 6 * 2^48 * Bj(t)
	assign t3e = $signed({4'b0, t3_s2});
	assign t2e = $signed({6'b0, t2_s2, 16'b0});
	assign t1e = $signed({7'b0, t_s2, 32'b0});

	always_comb begin
		b_c[0] = $signed({{2{u3_s2[53]}}, u3_s2});
		b_c[1] = 56'sd3 * t3e - 56'sd6 * t2e + 56'sd4 * ONE_CUBED;
		b_c[2] = 56'sd3 * t2e + 56'sd3 * t1e + ONE_CUBED - 56'sd3 * t3e;
		b_c[3] = t3e;
		for (int j = 0; j < 4; j++) begin
			mag_c[j]  = b_s3[j][55] ? -b_s3[j] : b_s3[j];
			magh_c[j] = mag_c[j] + WEIGHT_HALF;
			rp_c[j]   = {32'b0, h_s4[j]} * {32'b0, RECIP3};
		end
		for (int a = 0; a < 3; a++) begin
			sum_c[a] = ROUND_HALF;
			for (int j = 0; j < 4; j++)
				sum_c[a] = sum_c[a] + $signed({{2{prod_s7[a][j][63]}}, prod_s7[a][j]});
			res_c[a] = sat32($signed(sum_s8[a][65:30]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_q <= {last_q[7:1], cmd.last};

			t_s1  <= t_q;
			u_s1  <= u_c;
			t2_s1 <= t2_c;
			u2_s1 <= u2_c;

			t_s2  <= t_s1;
			t2_s2 <= t2_s1;
			t3_s2 <= {18'b0, t2_s1} * {35'b0, t_s1};
			u3_s2 <= $signed({{18{u2_s1[35]}}, u2_s1}) * $signed({{36{u_s1[17]}}, u_s1});

			for (int j = 0; j < 4; j++) begin
				b_s3[j]   <= b_c[j];
				h_s4[j]   <= magh_c[j][50:19];
				neg_s4[j] <= b_s3[j][55];
				q_s5[j]   <= rp_c[j][63:33];
				neg_s5[j] <= neg_s4[j];
				w_s6[j]   <= neg_s5[j] ? -$signed({1'b0, q_s5[j]}) : $signed({1'b0, q_s5[j]});
			end

			for (int a = 0; a < 3; a++) begin
				for (int j = 0; j < 4; j++)
					prod_s7[a][j] <= $signed({{32{win_q[a][j][31]}}, win_q[a][j]})
						* $signed({{32{w_s6[j][31]}}, w_s6[j]});
				sum_s8[a] <= sum_c[a];
			end

			out_q.sample_x    <= res_c[0];
			out_q.sample_y    <= res_c[1];
			out_q.sample_z    <= res_c[2];
			out_q.last_sample <= last_q[8];
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_q;

endmodule

// ===== hdl/cubic_bspline_tessellator.sv =====
// Uniform cubic B-spline tessellator: top level, register port and checks.
//
// Control points enter on the point channel (point_valid / point_stall),
// one beat per point. Once a curve holds three earlier points, each new
// point yields samples at t = 0, s, 2s, ... (t <= 1.001, at most 64) on the
// sample channel (sample_valid / sample_stall); the window's final beat has
// last_sample set. new_curve clears the history before the point is taken.
// After the point beat, samples go one sample a cycle (unless a stall
// holds them) through a 9-stage weight and dot-product pipeline. A point
// is taken once the previous window has been issued and has left the six
// stages ahead of the multipliers; a window holds 41 samples at the reset
// step of 1638. A stall on the sample channel while a sample waits holds
// the whole pipeline; the output register keeps its beat. Reset clears
// history, counters and valids and sets tension_step to 1638. tension_step
// sits at APB address 0.
module cubic_bspline_tessellator import cbt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               point_valid,
	output logic               point_stall,
	input  point_t             point,
	output logic               sample_valid,
	input  logic               sample_stall,
	output sample_t            sample
);

	logic [STEP_W-1:0]    step_q;
	logic [REG_IDX_W-1:0] reg_idx;
	cmd_t                 cmd;
	dp_sts_t              sts;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign prdata  = (reg_idx == REG_TENSION_STEP) ? {{(32-STEP_W){1'b0}}, step_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= STEP_RESET;
		else if (psel && penable && pwrite && (reg_idx == REG_TENSION_STEP))
			step_q <= pwdata[STEP_W-1:0];
	end

	cbt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.new_curve   (point.new_curve),
		.point_stall (point_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	cbt_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.point      (point),
		.step       (step_q),
		.cmd        (cmd),
		.stall      (sample_stall),
		.sts        (sts),
		.out_valid  (sample_valid),
		.out_sample (sample)
	);

`ifndef SYNTH
	a_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid && !point_stall) |-> !sts.busy)
		else $error("point beat taken while window still in use");

	a_issue_moves: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> sts.en)
		else $error("sample issued into a held pipeline");

	a_busy_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sts.busy) |-> $past(cmd.issue))
		else $error("pipeline filled without an issue");
`endif

endmodule
